[rtl/assert_macros.svh]
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// Condition that must hold on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
	else $error("assertion failed");
`endif

[rtl/dpfse_pkg.sv]
// Package: widths, codes and defaults for the page fault swap engine.
package dpfse_pkg;
	localparam int ADDR_W = 38;
	localparam int PAGE_W = 26;
	localparam int SEQ_W = 32;
	localparam int SLOT_W = 10;
	localparam int PAGE_SHIFT = 12;
	localparam int DEF_PAGE_ENTRIES = 64;
	localparam int DEF_SWAP_SLOTS = 1024;
	localparam int DEF_STACK_PAGES = 1;
	localparam int IN_W = 48;
	localparam int OUT_W = 104;

	typedef enum logic [1:0] {ST_UNMAPPED = 2'd0, ST_RESIDENT = 2'd1, ST_SWAPPED = 2'd2}
		pstate_t;

	typedef enum logic [2:0] {
		RS_PASS = 3'd0, RS_INVALID = 3'd1, RS_NEW = 3'd2, RS_RESTORED = 3'd3,
		RS_MEMFULL = 3'd4, RS_SWAPFULL = 3'd5, RS_MAPFAIL = 3'd6
	} rstat_t;

	typedef enum logic [1:0] {CA_STACK = 2'd0, CA_HEAP = 2'd1, CA_EXEC = 2'd2, CA_SWAP = 2'd3}
		cause_t;

	typedef enum logic [2:0] {
		REG_TEXT_BEGIN = 3'd0, REG_TEXT_LIMIT = 3'd1, REG_DATA_BEGIN = 3'd2,
		REG_DATA_LIMIT = 3'd3, REG_HEAP_BEGIN = 3'd4, REG_STACK_LIMIT = 3'd5
	} reg_t;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic [1:0] st;
		logic dirty;
		logic [SEQ_W-1:0] seq;
		logic [SLOT_W-1:0] slot;
	} entry_t;
	localparam int ENTRY_W = $bits(entry_t);
endpackage

[rtl/dpfse_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
module dpfse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[rtl/demand_page_fifo_swap_engine.sv]
// Top level: page fault engine with FIFO replacement and a swap slot bitmap.
// An eviction adds a scan of the page table for the oldest resident victim and, when the
// victim goes to swap, a scan of the bitmap for a free swap slot.
// One fault at a time; the input is taken again once the result word is taken.
// After reset a clearing pass zeroes the page table and bitmap memories before the
// first word is accepted.
`include "assert_macros.svh"
module demand_page_fifo_swap_engine
	import dpfse_pkg::*;
#(
	parameter int PAGE_ENTRIES = DEF_PAGE_ENTRIES,
	parameter int SWAP_SLOTS = DEF_SWAP_SLOTS,
	parameter int STACK_PAGES = DEF_STACK_PAGES
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [ADDR_W-1:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	// fault_addr[37:0], write_access, already_mapped, frame_free, retry_frame_free,
	// map_failed, zero fill
	input logic [IN_W-1:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// status[2:0], fault_cause[4:3], exec_perm, assigned_seq[37:6], swapin_slot[47:38],
	// load_exec, evicted, victim_addr[87:50], victim_swapped, swapout_slot[98:89], zero fill
	output logic [OUT_W-1:0] m_tdata
);
	localparam int IW = $clog2(PAGE_ENTRIES);
	localparam int WORDS = SWAP_SLOTS / 64;
	localparam int WW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CLR_N = (PAGE_ENTRIES > WORDS) ? PAGE_ENTRIES : WORDS;
	localparam int CW = $clog2(CLR_N + 1);
	localparam logic [ADDR_W:0] SPAN = ADDR_W'(STACK_PAGES + 1) << PAGE_SHIFT;

	typedef enum logic [13:0] {
		S_CLR = 14'h0001, S_IDLE = 14'h0002, S_RD = 14'h0004, S_CLS = 14'h0008,
		S_VSCAN = 14'h0010, S_VWAIT = 14'h0020, S_VDEC = 14'h0040, S_BSCAN = 14'h0080,
		S_BWAIT = 14'h0100, S_BDEC = 14'h0200, S_FIN = 14'h0400, S_FRD = 14'h0800,
		S_FWR = 14'h1000, S_OUT = 14'h2000
	} fsm_t;
	fsm_t st_q;

	logic [ADDR_W-1:0] tb_q, tl_q, db_q, dl_q, hb_q, sl_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tb_q <= '0; tl_q <= '0; db_q <= '0; dl_q <= '0; hb_q <= '0; sl_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEXT_BEGIN: tb_q <= cfg_data;
				REG_TEXT_LIMIT: tl_q <= cfg_data;
				REG_DATA_BEGIN: db_q <= cfg_data;
				REG_DATA_LIMIT: dl_q <= cfg_data;
				REG_HEAP_BEGIN: hb_q <= cfg_data;
				REG_STACK_LIMIT: sl_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// page table memory
	logic pt_we;
	logic [IW-1:0] pt_wa, pt_ra;
	entry_t pt_wd, pt_rd;
	logic [ENTRY_W-1:0] pt_rd_raw;
	dpfse_ram #(.WIDTH(ENTRY_W), .DEPTH(PAGE_ENTRIES)) u_pt (
		.clk(clk), .we(pt_we), .waddr(pt_wa), .wdata(pt_wd),
		.raddr(pt_ra), .rdata(pt_rd_raw)
	);
	assign pt_rd = entry_t'(pt_rd_raw);

	// bitmap memory
	logic bm_we;
	logic [WW-1:0] bm_wa, bm_ra;
	logic [63:0] bm_wd, bm_rd;
	dpfse_ram #(.WIDTH(64), .DEPTH(WORDS > 1 ? WORDS : 2)) u_bm (
		.clk(clk), .we(bm_we), .waddr(bm_wa), .wdata(bm_wd),
		.raddr(bm_ra), .rdata(bm_rd)
	);

	logic [ADDR_W-1:0] addr_q;
	logic wr_q, ff_q, rff_q, mf_q;
	logic [IW-1:0] idx_q;
	entry_t ent_q;
	logic [CW-1:0] cnt_q;
	logic [SEQ_W-1:0] nseq_q, best_q;
	logic [11:0] swc_q;
	logic [IW-1:0] vidx_q;
	logic vfound_q;
	entry_t vent_q;
	logic [63:0] word_q;
	logic [WW-1:0] word_idx_q;
	logic [OUT_W-1:0] out_q;
	logic [2:0] status_q;
	logic [1:0] cause_q;
	logic ev_q, vsw_q, restore_q;
	logic [ADDR_W-1:0] vaddr_q;
	logic [SLOT_W-1:0] swo_q;
	logic [CW-1:0] rcnt_q;
	logic rvalid_q;

	function automatic logic in_text(input logic [ADDR_W-1:0] a,
			input logic [ADDR_W-1:0] b, input logic [ADDR_W-1:0] l);
		return a >= b && a < l;
	endfunction

	logic [ADDR_W:0] bottom;
	logic bottom_wrap;
	assign bottom = {1'b0, sl_q} - SPAN;
	assign bottom_wrap = bottom[ADDR_W];

	// borrow on the stack bottom: empty stack, unbounded heap
	cause_t cls_cause;
	logic cls_ok;
	always_comb begin
		cls_cause = CA_STACK;
		cls_ok = 1'b1;
		if (ent_q.st == ST_SWAPPED)
			cls_cause = CA_SWAP;
		else if (!bottom_wrap && addr_q >= bottom[ADDR_W-1:0] && addr_q < sl_q)
			cls_cause = CA_STACK;
		else if (addr_q >= hb_q && (bottom_wrap || addr_q < bottom[ADDR_W-1:0]))
			cls_cause = CA_HEAP;
		else if (in_text(addr_q, tb_q, tl_q) || in_text(addr_q, db_q, dl_q))
			cls_cause = CA_EXEC;
		else
			cls_ok = 1'b0;
	end

	logic [5:0] ffz;
	logic ffz_ok;
	always_comb begin
		ffz = '0;
		ffz_ok = 1'b0;
		for (int b = 63; b >= 0; b--) begin
			if (!word_q[b]) begin
				ffz = 6'(b);
				ffz_ok = 1'b1;
			end
		end
	end

	assign s_tready = (st_q == S_IDLE);
	assign m_tvalid = (st_q == S_OUT) && rvalid_q;
	assign m_tdata = out_q;

	logic [ADDR_W-1:0] in_addr;
	assign in_addr = {s_tdata[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};

	always_comb begin
		pt_we = 1'b0; pt_wa = idx_q; pt_wd = '0; pt_ra = idx_q;
		bm_we = 1'b0; bm_wa = word_idx_q; bm_wd = '0; bm_ra = word_idx_q;
		unique case (st_q)
			S_CLR: begin
				pt_we = cnt_q < CW'(PAGE_ENTRIES); pt_wa = cnt_q[IW-1:0];
				bm_we = cnt_q < CW'(WORDS); bm_wa = cnt_q[WW-1:0];
			end
			S_IDLE: pt_ra = in_addr[PAGE_SHIFT+IW-1:PAGE_SHIFT];
			S_VSCAN, S_VWAIT: pt_ra = cnt_q[IW-1:0];
			S_BSCAN, S_BWAIT: bm_ra = cnt_q[WW-1:0];
			S_BDEC: begin
				if (ffz_ok) begin
					bm_we = 1'b1; bm_wa = word_idx_q;
					bm_wd = word_q | (64'd1 << ffz);
					pt_we = 1'b1; pt_wa = vidx_q;
					pt_wd = vent_q; pt_wd.st = ST_SWAPPED;
					pt_wd.slot = SLOT_W'({word_idx_q, ffz});
				end
			end
			S_FIN: begin
				if (ev_q && !vsw_q) begin
					pt_we = 1'b1; pt_wa = vidx_q;
					pt_wd = vent_q; pt_wd.st = ST_UNMAPPED; pt_wd.slot = '0;
				end
				bm_ra = ent_q.slot[SLOT_W-1:6];
			end
			S_FRD: begin
				pt_we = 1'b1; pt_wa = idx_q; pt_wd = ent_q;
				pt_wd.st = ST_RESIDENT; pt_wd.seq = nseq_q; pt_wd.slot = '0;
				if (!restore_q) begin
					pt_wd.page = addr_q[PAGE_SHIFT+PAGE_W-1:PAGE_SHIFT];
					pt_wd.dirty = wr_q;
				end
				bm_ra = ent_q.slot[SLOT_W-1:6];
			end
			S_FWR: begin
				bm_we = restore_q && ({1'b0, ent_q.slot} < (SLOT_W+1)'(SWAP_SLOTS));
				bm_wa = ent_q.slot[SLOT_W-1:6];
				bm_wd = bm_rd & ~(64'd1 << ent_q.slot[5:0]);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR; cnt_q <= '0; nseq_q <= '0; swc_q <= '0; rvalid_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(CLR_N - 1)) st_q <= S_IDLE;
				end
				S_IDLE: if (s_tvalid) begin
					addr_q <= in_addr; wr_q <= s_tdata[38];
					ff_q <= s_tdata[40]; rff_q <= s_tdata[41]; mf_q <= s_tdata[42];
					idx_q <= in_addr[PAGE_SHIFT+IW-1:PAGE_SHIFT];
					status_q <= RS_PASS; cause_q <= CA_STACK;
					ev_q <= 1'b0; vsw_q <= 1'b0; vaddr_q <= '0; swo_q <= '0;
					st_q <= s_tdata[39] ? S_OUT : S_RD;
					out_q <= '0;
				end
				S_RD: begin ent_q <= pt_rd; st_q <= S_CLS; end
				S_CLS: begin
					restore_q <= (ent_q.st == ST_SWAPPED);
					cnt_q <= '0; vfound_q <= 1'b0; rcnt_q <= '0; rvalid_q <= 1'b0;
					if (cls_ok) begin
						cause_q <= cls_cause;
						st_q <= ff_q ? S_FIN : S_VSCAN;
					end else begin
						status_q <= RS_INVALID; st_q <= S_OUT;
					end
				end
				S_VSCAN: begin
					cnt_q <= cnt_q + 1'b1; rcnt_q <= cnt_q; rvalid_q <= 1'b1;
					if (rvalid_q && pt_rd.st == ST_RESIDENT &&
							(!vfound_q || pt_rd.seq < best_q)) begin
						vfound_q <= 1'b1; best_q <= pt_rd.seq;
						vidx_q <= rcnt_q[IW-1:0]; vent_q <= pt_rd;
					end
					if (cnt_q == CW'(PAGE_ENTRIES - 1)) st_q <= S_VWAIT;
				end
				S_VWAIT: begin
					rvalid_q <= 1'b0;
					if (pt_rd.st == ST_RESIDENT && (!vfound_q || pt_rd.seq < best_q)) begin
						vfound_q <= 1'b1; best_q <= pt_rd.seq;
						vidx_q <= rcnt_q[IW-1:0]; vent_q <= pt_rd;
					end
					st_q <= S_VDEC;
				end
				S_VDEC: begin
					vaddr_q <= {vent_q.page, {PAGE_SHIFT{1'b0}}};
					if (!vfound_q) begin
						status_q <= RS_MEMFULL; st_q <= S_OUT;
					end else if (vent_q.dirty ||
							!in_text({vent_q.page, {PAGE_SHIFT{1'b0}}}, tb_q, tl_q)) begin
						if (swc_q >= 12'(SWAP_SLOTS)) begin
							status_q <= RS_SWAPFULL; st_q <= S_OUT;
						end else begin
							cnt_q <= '0; st_q <= S_BSCAN;
						end
					end else begin
						ev_q <= 1'b1; st_q <= S_FIN;
					end
				end
				S_BSCAN: begin
					cnt_q <= cnt_q + 1'b1; st_q <= S_BWAIT;
					word_idx_q <= cnt_q[WW-1:0];
				end
				S_BWAIT: begin word_q <= bm_rd; st_q <= S_BDEC; end
				S_BDEC: begin
					if (ffz_ok) begin
						ev_q <= 1'b1; vsw_q <= 1'b1; swo_q <= SLOT_W'({word_idx_q, ffz});
						swc_q <= swc_q + 1'b1;
						if (vidx_q == idx_q) begin
							ent_q.st <= ST_SWAPPED;
							ent_q.slot <= SLOT_W'({word_idx_q, ffz});
						end
						st_q <= S_FIN;
					end else if (cnt_q == CW'(WORDS)) begin
						status_q <= RS_SWAPFULL; st_q <= S_OUT; vaddr_q <= '0;
					end else st_q <= S_BSCAN;
				end
				S_FIN: begin
					if (ev_q && !vsw_q && vidx_q == idx_q) ent_q.st <= ST_UNMAPPED;
					if (!ff_q && !(ev_q && rff_q)) begin
						status_q <= RS_MEMFULL; st_q <= S_OUT;
					end else if (mf_q) begin
						status_q <= RS_MAPFAIL; st_q <= S_OUT;
					end else st_q <= S_FRD;
				end
				S_FRD: st_q <= S_FWR;
				S_FWR: begin
					nseq_q <= nseq_q + 1'b1;
					if (restore_q) begin
						status_q <= RS_RESTORED;
						if (swc_q != '0) swc_q <= swc_q - 1'b1;
					end else status_q <= RS_NEW;
					st_q <= S_OUT;
				end
				S_OUT: begin
					out_q[2:0] <= status_q;
					out_q[4:3] <= (status_q == RS_PASS || status_q == RS_INVALID) ? 2'd0 : cause_q;
					out_q[49] <= ev_q; out_q[87:50] <= ev_q ? vaddr_q : '0;
					out_q[88] <= vsw_q; out_q[98:89] <= vsw_q ? swo_q : '0;
					if (status_q == RS_NEW || status_q == RS_RESTORED) begin
						out_q[5] <= in_text(addr_q, tb_q, tl_q);
						out_q[37:6] <= nseq_q - 1'b1;
					end
					if (status_q == RS_RESTORED) out_q[47:38] <= ent_q.slot;
					if (status_q == RS_NEW) out_q[48] <= (cause_q == CA_EXEC);
					if (m_tready && rvalid_q) st_q <= S_IDLE;
					rvalid_q <= !(m_tready && rvalid_q);
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_IMP(a_sready_idle, clk, arst_n, s_tready, !m_tvalid)
	`ASSERT_IMP(a_swc_bound, clk, arst_n, 1'b1, swc_q <= 12'(SWAP_SLOTS))
	`ASSERT_IMP(a_clr_no_in, clk, arst_n, st_q == S_CLR, !s_tready)
endmodule

[bench/testbench.sv]
// Testbench for the page fault swap engine: directed and random faults, checked against a predictor.
module testbench;
	import dpfse_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_ENTRIES = DEF_PAGE_ENTRIES;
	localparam int N_SLOTS = DEF_SWAP_SLOTS;
	localparam int DRAIN_CYCLES = N_ENTRIES + N_SLOTS / 64 + 20;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [4:0] pad;
		logic map_failed;
		logic retry_frame_free;
		logic frame_free;
		logic already_mapped;
		logic write_access;
		logic [ADDR_W-1:0] fault_addr;
	} fault_t;

	typedef struct packed {
		logic [4:0] pad;
		logic [SLOT_W-1:0] swapout_slot;
		logic victim_swapped;
		logic [ADDR_W-1:0] victim_addr;
		logic evicted;
		logic load_exec;
		logic [SLOT_W-1:0] swapin_slot;
		logic [SEQ_W-1:0] assigned_seq;
		logic exec_perm;
		cause_t fault_cause;
		rstat_t status;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [ADDR_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	demand_page_fifo_swap_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// predictor state
	logic [ADDR_W-1:0] seg_reg [6];
	logic [PAGE_W-1:0] pt_page [N_ENTRIES];
	pstate_t pt_state [N_ENTRIES];
	logic pt_dirty [N_ENTRIES];
	logic [SEQ_W-1:0] pt_seq [N_ENTRIES];
	logic [SLOT_W-1:0] pt_slot [N_ENTRIES];
	logic [SEQ_W-1:0] seq_next;
	logic [N_SLOTS-1:0] slot_busy;
	int swapped_pages;

	outcome_t pending_results [$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	function automatic logic in_text(logic [ADDR_W-1:0] a);
		return a >= seg_reg[REG_TEXT_BEGIN] && a < seg_reg[REG_TEXT_LIMIT];
	endfunction

	// 0 no victim, 1 evicted, 2 swap exhausted
	function automatic int evict_oldest(inout outcome_t r);
		int v;
		int s;
		logic [ADDR_W-1:0] va;
		v = -1;
		s = -1;
		for (int i = 0; i < N_ENTRIES; i++)
			if (pt_state[i] == ST_RESIDENT && (v < 0 || pt_seq[i] < pt_seq[v]))
				v = i;
		if (v < 0)
			return 0;
		va = {pt_page[v], 12'h000};
		if (pt_dirty[v] || !in_text(va)) begin
			if (swapped_pages >= N_SLOTS)
				return 2;
			for (int j = 0; j < N_SLOTS; j++)
				if (s < 0 && !slot_busy[j])
					s = j;
			if (s < 0)
				return 2;
			slot_busy[s] = 1'b1;
			pt_state[v] = ST_SWAPPED;
			pt_slot[v] = s[SLOT_W-1:0];
			swapped_pages++;
			r.victim_swapped = 1'b1;
			r.swapout_slot = s[SLOT_W-1:0];
		end else begin
			pt_state[v] = ST_UNMAPPED;
			pt_slot[v] = '0;
		end
		r.evicted = 1'b1;
		r.victim_addr = va;
		return 1;
	endfunction

	function automatic outcome_t resolve_fault(fault_t f);
		outcome_t r;
		logic [ADDR_W-1:0] a;
		logic [63:0] bottom;
		int idx;
		int ev;
		logic restore;
		r = '0;
		a = {f.fault_addr[ADDR_W-1:12], 12'h000};
		idx = a[12 +: $clog2(N_ENTRIES)];
		restore = 1'b0;
		if (f.already_mapped)
			return r;
		if (pt_state[idx] == ST_SWAPPED) begin
			restore = 1'b1;
			r.fault_cause = CA_SWAP;
		end else begin
			bottom = 64'(seg_reg[REG_STACK_LIMIT]) - 64'((DEF_STACK_PAGES + 1) << 12);
			if (64'(a) >= bottom && a < seg_reg[REG_STACK_LIMIT])
				r.fault_cause = CA_STACK;
			else if (a >= seg_reg[REG_HEAP_BEGIN] && 64'(a) < bottom)
				r.fault_cause = CA_HEAP;
			else if (in_text(a) ||
					(a >= seg_reg[REG_DATA_BEGIN] && a < seg_reg[REG_DATA_LIMIT]))
				r.fault_cause = CA_EXEC;
			else begin
				r.status = RS_INVALID;
				return r;
			end
		end
		if (!f.frame_free) begin
			ev = evict_oldest(r);
			if (!(ev == 1 && f.retry_frame_free)) begin
				r.status = (ev == 2) ? RS_SWAPFULL : RS_MEMFULL;
				return r;
			end
		end
		if (f.map_failed) begin
			r.status = RS_MAPFAIL;
			return r;
		end
		r.exec_perm = in_text(a);
		r.assigned_seq = seq_next;
		pt_state[idx] = ST_RESIDENT;
		pt_seq[idx] = seq_next;
		seq_next++;
		if (restore) begin
			slot_busy[pt_slot[idx]] = 1'b0;
			if (swapped_pages > 0)
				swapped_pages--;
			r.swapin_slot = pt_slot[idx];
			pt_slot[idx] = '0;
			r.status = RS_RESTORED;
		end else begin
			pt_page[idx] = a[ADDR_W-1:12];
			pt_dirty[idx] = f.write_access;
			pt_slot[idx] = '0;
			r.status = RS_NEW;
			r.load_exec = (r.fault_cause == CA_EXEC);
		end
		return r;
	endfunction

	task automatic send_fault(fault_t f);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= f;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(resolve_fault(f));
		@(negedge clk);
	endtask

	task automatic fault(logic [ADDR_W-1:0] a, logic wr, logic mapped, logic ff, logic rf,
			logic mf);
		fault_t f;
		f = '0;
		f.fault_addr = a;
		f.write_access = wr;
		f.already_mapped = mapped;
		f.frame_free = ff;
		f.retry_frame_free = rf;
		f.map_failed = mf;
		send_fault(f);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(reg_t r, logic [ADDR_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		seg_reg[r] = v;
	endtask

	task automatic set_layout(logic [ADDR_W-1:0] tb, tl, db, dl, hb, sl);
		drain();
		write_reg(REG_TEXT_BEGIN, tb);
		write_reg(REG_TEXT_LIMIT, tl);
		write_reg(REG_DATA_BEGIN, db);
		write_reg(REG_DATA_LIMIT, dl);
		write_reg(REG_HEAP_BEGIN, hb);
		write_reg(REG_STACK_LIMIT, sl);
	endtask

	function automatic logic [ADDR_W-1:0] pick_addr(logic [ADDR_W-1:0] sl);
		logic [ADDR_W-1:0] low;
		low = ADDR_W'($urandom_range(0, 4095));
		case ($urandom_range(0, 9))
			0, 1, 2: return 38'h100000 + (ADDR_W'($urandom_range(0, 127)) << 12) + low;
			3, 4, 5: return 38'h180000 + (ADDR_W'($urandom_range(0, 95)) << 12) + low;
			6, 7: return sl - (ADDR_W'($urandom_range(1, 2)) << 12) + low;
			default: return ADDR_W'({$urandom, $urandom});
		endcase
	endfunction

	task automatic random_faults(int n, logic [ADDR_W-1:0] sl);
		for (int i = 0; i < n; i++)
			fault(pick_addr(sl), 1'($urandom_range(0, 1)), $urandom_range(0, 99) < 8,
				1'($urandom_range(0, 1)), $urandom_range(0, 99) < 85,
				$urandom_range(0, 99) < 5);
	endtask

	task automatic test_directed;
		set_layout(38'h100000, 38'h140000, 38'h140000, 38'h180000, 38'h180000, 38'h400000);
		fault(38'h180000, 1, 0, 0, 1, 0);          // nothing resident: memfull
		fault(38'h3FFFFFFFFF, 1, 1, 1, 1, 1);      // already mapped
		fault(38'h3FFFFFFFFF, 1, 0, 1, 1, 1);      // invalid
		fault(38'h3FF123, 1, 0, 1, 1, 0);          // stack
		fault(38'h3FE000, 0, 0, 1, 1, 0);          // stack bottom
		fault(38'h180FFF, 1, 0, 1, 1, 0);          // heap
		fault(38'h101000, 0, 0, 1, 1, 0);          // text, clean
		fault(38'h141000, 1, 0, 1, 1, 0);          // data
		fault(38'h13F000, 0, 0, 1, 1, 1);          // map fail
		fault(38'h182000, 0, 0, 0, 1, 0);          // evict dirty stack page
		fault(38'h183000, 0, 0, 0, 1, 0);          // evict stack bottom
		fault(38'h184000, 0, 0, 0, 1, 0);          // evict heap
		fault(38'h185000, 0, 0, 0, 1, 0);          // evict dirty data page: swap out
		fault(38'h1BF000, 0, 0, 1, 1, 0);          // aliases swapped stack: restore
		fault(38'h186000, 0, 0, 0, 0, 0);          // eviction then retry fails
		fault(38'h187000, 0, 0, 0, 1, 1);          // eviction then map fail
		fault(38'h1BE000, 1, 0, 0, 1, 0);          // restore with eviction
	endtask

	task automatic test_random_idling;
		int pct [4][2] = '{'{0, 0}, {47, 0}, {0, 47}, {36, 36}};
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = pct[p][0];
			recv_stall_pct = pct[p][1];
			random_faults(100, 38'h400000);
		end
	endtask

	task automatic test_stack_underflow;
		set_layout(38'h100000, 38'h140000, 38'h140000, 38'h180000, 38'h180000, 38'h001000);
		send_idle_pct = 20;
		recv_stall_pct = 20;
		random_faults(100, 38'h001000);
	endtask

	task automatic test_extreme_layout;
		set_layout('1, '1, '0, '0, '1, '1);
		random_faults(60, '1);
		set_layout('0, '1, '1, '0, '0, '0);
		random_faults(60, 38'h400000);
		set_layout(38'h100000, 38'h140000, 38'h140000, 38'h180000, 38'h180000, 38'h400000);
		send_idle_pct = 10;
		recv_stall_pct = 10;
		random_faults(100, 38'h400000);
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk) begin
		outcome_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", got);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.fault_cause !== want.fault_cause ||
						got.exec_perm !== want.exec_perm ||
						got.assigned_seq !== want.assigned_seq ||
						got.swapin_slot !== want.swapin_slot ||
						got.load_exec !== want.load_exec || got.evicted !== want.evicted ||
						got.victim_addr !== want.victim_addr ||
						got.victim_swapped !== want.victim_swapped ||
						got.swapout_slot !== want.swapout_slot || got.pad !== want.pad) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h got %h", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < 6; i++)
			seg_reg[i] = '0;
		for (int i = 0; i < N_ENTRIES; i++) begin
			pt_page[i] = '0;
			pt_state[i] = ST_UNMAPPED;
			pt_dirty[i] = 1'b0;
			pt_seq[i] = '0;
			pt_slot[i] = '0;
		end
		seq_next = '0;
		slot_busy = '0;
		swapped_pages = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_idling();
		test_stack_underflow();
		test_extreme_layout();
		drain();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
